// ----- hdl/dual_wheel_pid_position_control_macros.svh -----
// ----------------------------------------------------------------------------
// dual wheel pid assertion macros
// concurrent assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef DUAL_WHEEL_PID_POSITION_CONTROL_MACROS_SVH
`define DUAL_WHEEL_PID_POSITION_CONTROL_MACROS_SVH
`ifndef SYNTHESIS
`define DWP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DWP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define DWP_ASSERT(lbl, clk, rst_n, prop, msg)
`define DWP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- hdl/dwp_pkg.sv -----
// ----------------------------------------------------------------------------
// dwp_pkg
// shared types and constants of the dual wheel position controller
// ----------------------------------------------------------------------------
package dwp_pkg;
  localparam int COUNT_WIDTH = 24;
  localparam int SUM_WIDTH = 48;
  localparam int ACC_WIDTH = 64;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    OP_EDGE_L = 2'd0,
    OP_EDGE_R = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_DPS  = 3'd0,
    REG_GM   = 3'd1,
    REG_KP_L = 3'd2,
    REG_KI_L = 3'd3,
    REG_KD_L = 3'd4,
    REG_KP_R = 3'd5,
    REG_KI_R = 3'd6,
    REG_KD_R = 3'd7
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIST, ST_ERR, ST_GOAL, ST_P, ST_I, ST_D, ST_SAT, ST_NEXT, ST_OUT
  } st_e;

  typedef struct packed {
    logic               is_tick;
    logic               wheel;
    logic signed [31:0] target_l;
    logic signed [31:0] target_r;
    logic               stop;
  } cmd_t;

  typedef struct packed {
    logic [7:0] drive_l;
    logic       turn_l;
    logic [7:0] drive_r;
    logic       turn_r;
    logic [1:0] at_goal;
  } res_t;
endpackage

// ----- hdl/dwp_front.sv -----
// ----------------------------------------------------------------------------
// dwp_front
// classifies input items and queues commands for the back end
// ----------------------------------------------------------------------------
module dwp_front import dwp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] target_left_i,
  input  logic signed [31:0] target_right_i,
  input  logic               stop_at_goal_i,
  output logic               cmd_valid_o,
  output cmd_t               cmd_o,
  input  logic               cmd_take_i
);
  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W:0]   wp_q, rp_q;
  logic              wr, keep;
  cmd_t              c;

  assign full_o = (wp_q[QPTR_W] != rp_q[QPTR_W]) && (wp_q[QPTR_W-1:0] == rp_q[QPTR_W-1:0]);
  assign cmd_valid_o = wp_q != rp_q;
  assign cmd_o = mem_q[rp_q[QPTR_W-1:0]];
  assign keep = (opcode_i != OP_NONE);
  assign wr = push_i && !full_o && keep;

  always_comb begin
    c.is_tick  = opcode_i == OP_TICK;
    c.wheel    = opcode_i == OP_EDGE_R;
    c.target_l = target_left_i;
    c.target_r = target_right_i;
    c.stop     = stop_at_goal_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q[QPTR_W-1:0]] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (cmd_take_i && cmd_valid_o) rp_q <= rp_q + 1'b1;
    end
  end
endmodule

// ----- hdl/dwp_back.sv -----
// ----------------------------------------------------------------------------
// dwp_back
// encoder counting and sequenced pid step with one shared multiplier
// ----------------------------------------------------------------------------
module dwp_back import dwp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_take_o,
  output logic        res_valid_o,
  output res_t        res_o,
  input  logic        res_take_i
);
  localparam logic signed [COUNT_WIDTH-1:0] CMAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CMIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
  localparam logic signed [SUM_WIDTH-1:0] SMAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SMIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_WIDTH-1:0] DLIM = 64'sd255 <<< 24;

  logic [15:0]        dps_q;
  logic [30:0]        gm_q;
  logic signed [15:0] kp_q [2];
  logic signed [15:0] ki_q [2];
  logic signed [15:0] kd_q [2];

  logic signed [COUNT_WIDTH-1:0] cnt_q [2];
  logic                          hd_q [2];
  logic signed [SUM_WIDTH-1:0]   sum_q [2];
  logic signed [31:0]            pri_q [2];

  st_e st_q, st_d;
  logic                  w_q;
  cmd_t                  cmd_q;
  logic signed [31:0]    err_q;
  logic signed [32:0]    diff_q;
  logic signed [ACC_WIDTH-1:0] acc_q;
  logic signed [ACC_WIDTH-1:0] prod_q;
  logic                  goal_q;
  logic [1:0]            ng_q;
  res_t                  res_q;
  logic                  rv_q;

  logic signed [48:0] ma;
  logic signed [16:0] mb;
  logic signed [65:0] mp;
  logic signed [32:0] errw;
  logic signed [49:0] sumw;
  logic signed [SUM_WIDTH-1:0] sumn;
  logic signed [31:0] tgt;
  logic signed [ACC_WIDTH-1:0] acc_sum;
  logic signed [ACC_WIDTH-1:0] spd;
  logic [ACC_WIDTH-1:0] mag;
  logic signed [32:0] gmw;
  logic goal_c;
  logic neg, dir, edge_up;
  logic signed [COUNT_WIDTH:0] cinc;

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (st_q)
      ST_DIST: begin
        ma = 49'(cnt_q[w_q]);
        mb = $signed({1'b0, dps_q});
      end
      ST_P: begin
        ma = 49'(err_q);
        mb = 17'(kp_q[w_q]);
      end
      ST_I: begin
        ma = 49'(sum_q[w_q]);
        mb = 17'(ki_q[w_q]);
      end
      ST_D: begin
        ma = 49'(diff_q);
        mb = 17'(kd_q[w_q]);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    mp = ma * mb;
  end

  always_comb begin
    tgt = w_q ? cmd_q.target_r : cmd_q.target_l;
    errw = 33'(tgt) - 33'(prod_q > 64'sd2147483647 ? 64'sd2147483647 :
                          prod_q < -64'sd2147483648 ? -64'sd2147483648 : prod_q);
    gmw = $signed({2'b00, gm_q});
    goal_c = cmd_q.stop && (33'(err_q) > -gmw) && (33'(err_q) < gmw);
    sumw = 50'(sum_q[w_q]) + 50'(err_q);
    sumn = sumw > 50'(SMAX) ? SMAX : sumw < 50'(SMIN) ? SMIN : SUM_WIDTH'(sumw);
    acc_sum = acc_q + prod_q;
    spd = goal_q ? '0 : (acc_sum > DLIM ? DLIM : acc_sum < -DLIM ? -DLIM : acc_sum);
    neg = spd < 0;
    mag = neg ? 64'(-spd) : 64'(spd);
    dir = neg ^ w_q;
    edge_up = cmd_i.wheel ? hd_q[1] : !hd_q[0];
    cinc = edge_up ? (COUNT_WIDTH+1)'(cnt_q[cmd_i.wheel]) + 1'b1
                   : (COUNT_WIDTH+1)'(cnt_q[cmd_i.wheel]) - 1'b1;
  end

  always_comb begin
    st_d = st_q;
    cmd_take_o = 1'b0;
    case (st_q)
      ST_IDLE: if (cmd_valid_i) begin
        if (!cmd_i.is_tick) cmd_take_o = 1'b1;
        else if (!rv_q) begin
          cmd_take_o = 1'b1;
          st_d = ST_DIST;
        end
      end
      ST_DIST: st_d = ST_ERR;
      ST_ERR:  st_d = ST_GOAL;
      ST_GOAL: st_d = ST_P;
      ST_P:    st_d = ST_I;
      ST_I:    st_d = ST_D;
      ST_D:    st_d = ST_SAT;
      ST_SAT:  st_d = ST_NEXT;
      ST_NEXT: st_d = w_q ? ST_OUT : ST_DIST;
      ST_OUT:  st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= ST_IDLE;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dps_q <= '0; gm_q <= '0;
      kp_q[0] <= '0; ki_q[0] <= '0; kd_q[0] <= '0;
      kp_q[1] <= '0; ki_q[1] <= '0; kd_q[1] <= '0;
      cnt_q[0] <= '0; cnt_q[1] <= '0;
      hd_q[0] <= 1'b0; hd_q[1] <= 1'b1;
      sum_q[0] <= '0; sum_q[1] <= '0;
      pri_q[0] <= '0; pri_q[1] <= '0;
      rv_q <= 1'b0;
      w_q <= 1'b0;
      ng_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_DPS:  dps_q <= cfg_data_i[15:0];
          REG_GM:   gm_q <= cfg_data_i;
          REG_KP_L: kp_q[0] <= cfg_data_i[15:0];
          REG_KI_L: ki_q[0] <= cfg_data_i[15:0];
          REG_KD_L: kd_q[0] <= cfg_data_i[15:0];
          REG_KP_R: kp_q[1] <= cfg_data_i[15:0];
          REG_KI_R: ki_q[1] <= cfg_data_i[15:0];
          REG_KD_R: kd_q[1] <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (res_take_i && rv_q) rv_q <= 1'b0;
      case (st_q)
        ST_IDLE: if (cmd_take_o) begin
          if (!cmd_i.is_tick) begin
            cnt_q[cmd_i.wheel] <= cinc > (COUNT_WIDTH+1)'(CMAX) ? CMAX :
                                  cinc < (COUNT_WIDTH+1)'(CMIN) ? CMIN :
                                  COUNT_WIDTH'(cinc);
          end else begin
            w_q <= 1'b0;
            ng_q <= '0;
          end
        end
        ST_GOAL: begin
          if (goal_c) begin
            sum_q[w_q] <= '0;
            pri_q[w_q] <= '0;
            ng_q <= ng_q + 1'b1;
          end else begin
            sum_q[w_q] <= sumn;
          end
        end
        ST_SAT: begin
          hd_q[w_q] <= dir;
          if (!goal_q) pri_q[w_q] <= err_q;
        end
        ST_NEXT: w_q <= 1'b1;
        ST_OUT: begin
          rv_q <= 1'b1;
          if (ng_q == 2'd2) begin
            cnt_q[0] <= '0;
            cnt_q[1] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) cmd_q <= cmd_i;
    prod_q <= 64'(mp);
    case (st_q)
      ST_ERR: begin
        err_q <= errw > 33'sd2147483647 ? 32'sh7fffffff :
                 errw < -33'sd2147483648 ? 32'sh80000000 : 32'(errw);
      end
      ST_GOAL: begin
        goal_q <= goal_c;
        diff_q <= 33'(err_q) - 33'(pri_q[w_q]);
      end
      ST_I: acc_q <= prod_q;
      ST_D: acc_q <= acc_q + prod_q;
      ST_SAT: begin
        if (w_q) begin
          res_q.drive_r <= mag[31:24];
          res_q.turn_r  <= dir;
        end else begin
          res_q.drive_l <= mag[31:24];
          res_q.turn_l  <= dir;
        end
      end
      ST_OUT: res_q.at_goal <= ng_q;
      default: ;
    endcase
  end

  assign res_valid_o = rv_q;
  assign res_o = res_q;
endmodule

// ----- hdl/dual_wheel_pid_position_control.sv -----
// ----------------------------------------------------------------------------
// dual_wheel_pid_position_control
// two wheel position pid with encoder step counting
// ----------------------------------------------------------------------------
// encoder edge items are taken in idle; a control tick is taken in idle,
// then per wheel runs dist, err, goal, p, i, d, sat and next, the shared
// 49x17 multiplier serving distance, p, i and d, and out posts the result.
// a four entry command queue parts input from the back end, and one result
// register holds the answer; a tick waits until the previous result is popped.
`include "dual_wheel_pid_position_control_macros.svh"
module dual_wheel_pid_position_control import dwp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] target_left_i,
  input  logic signed [31:0] target_right_i,
  input  logic               stop_at_goal_i,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         drive_left_o,
  output logic               turn_left_o,
  output logic [7:0]         drive_right_o,
  output logic               turn_right_o,
  output logic [1:0]         wheels_at_goal_o
);
  logic cmd_valid, cmd_take, res_valid;
  cmd_t cmd;
  res_t res;

  dwp_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .opcode_i, .target_left_i,
    .target_right_i, .stop_at_goal_i, .cmd_valid_o(cmd_valid), .cmd_o(cmd),
    .cmd_take_i(cmd_take)
  );

  dwp_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cmd_valid_i(cmd_valid),
    .cmd_i(cmd), .cmd_take_o(cmd_take), .res_valid_o(res_valid), .res_o(res),
    .res_take_i(pop)
  );

  assign empty = !res_valid;
  assign drive_left_o = res.drive_l;
  assign turn_left_o = res.turn_l;
  assign drive_right_o = res.drive_r;
  assign turn_right_o = res.turn_r;
  assign wheels_at_goal_o = res.at_goal;

  `DWP_ASSERT(a_goal_range, clk_i, rst_ni, empty || wheels_at_goal_o != 2'd3, "goal count out of range")
  `DWP_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(wheels_at_goal_o), "result lost")
  `DWP_ASSERT(a_take, clk_i, rst_ni, !cmd_take || cmd_valid, "command taken from empty queue")
endmodule
